// ===== design/rrct_pkg.sv =====
// rrct_pkg: shared types, codes and helpers for the range read cache tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package rrct_pkg;

  localparam int SLOTS_DEFAULT = 4;
  localparam int SLOT_FIELD_W  = 4;
  localparam int HINT_W        = 16;
  localparam int DIGIT_W       = 4;
  localparam int MOD_STEPS     = HINT_W / DIGIT_W;

  localparam logic [1:0] OP_LOOKUP   = 2'd0;
  localparam logic [1:0] OP_BEGIN    = 2'd1;
  localparam logic [1:0] OP_COMPLETE = 2'd2;
  localparam logic [1:0] OP_DISABLE  = 2'd3;

  localparam logic CFG_BUFFER_SIZE = 1'b0;
  localparam logic CFG_ALIGN_LOG2  = 1'b1;

  localparam logic [31:0] BUF_SIZE_RST  = 32'd65536;
  localparam logic [4:0]  ALIGN_RST     = 5'd9;

  typedef struct packed {
    logic [1:0]        op;
    logic [63:0]       offset;
    logic [HINT_W-1:0] slot_hint;
    logic [31:0]       byte_cnt;
  } in_item_t;

  typedef struct packed {
    logic                    status;
    logic                    hit;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [31:0]             position;
    logic [31:0]             length;
    logic [63:0]             read_offset;
  } out_item_t;

  typedef struct packed {
    logic [63:0]             sub0_a;
    logic [63:0]             sub0_b;
    logic [63:0]             sub1_a;
    logic [63:0]             sub1_b;
    logic [63:0]             add_a;
    logic [31:0]             add_b;
    logic [SLOT_FIELD_W-1:0] rem;
    logic [DIGIT_W-1:0]      digit;
  } alu_req_t;

  typedef struct packed {
    logic [63:0]             diff0;
    logic                    brw0;
    logic [63:0]             diff1;
    logic                    brw1;
    logic [63:0]             sum;
    logic                    carry;
    logic [SLOT_FIELD_W-1:0] rem;
  } alu_rsp_t;

  typedef struct packed {
    logic        we_start;
    logic        we_end;
    logic [63:0] rng_start;
    logic [63:0] rng_end;
  } slot_wr_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

// ===== design/rrct_alu.sv =====
// rrct_alu: shared arithmetic unit of the tracker: two 64-bit subtractors with
// borrow, a 64-bit saturating-add source and one hex digit of hint mod SLOTS.
// Depends on rrct_pkg.
`timescale 1ns / 1ps
module rrct_alu import rrct_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  always_comb begin
    logic [4:0]              t;
    logic [SLOT_FIELD_W-1:0] r;
    {rsp_o.brw0, rsp_o.diff0} = {1'b0, req_i.sub0_a} - {1'b0, req_i.sub0_b};
    {rsp_o.brw1, rsp_o.diff1} = {1'b0, req_i.sub1_a} - {1'b0, req_i.sub1_b};
    {rsp_o.carry, rsp_o.sum}  = {1'b0, req_i.add_a} + {33'd0, req_i.add_b};
    // remainder update, one hint bit per step, msb first
    r = req_i.rem;
    for (int k = DIGIT_W - 1; k >= 0; k--) begin
      t = {r, req_i.digit[k]};
      if (t >= 5'(SLOTS)) begin
        t = t - 5'(SLOTS);
      end
      r = t[SLOT_FIELD_W-1:0];
    end
    rsp_o.rem = r;
  end

endmodule

// ===== design/rrct_slot_file.sv =====
// rrct_slot_file: per-slot byte range registers, one read and one write port.
// Depends on rrct_pkg.
`timescale 1ns / 1ps
module rrct_slot_file import rrct_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic [63:0]      rd_start_o,
  output logic [63:0]      rd_end_o,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  slot_wr_t         wr_i
);

  logic [63:0] start_q [SLOTS];
  logic [63:0] end_q   [SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        start_q[i] <= '0;
        end_q[i]   <= '0;
      end
    end else begin
      if (wr_i.we_start) begin
        start_q[wr_idx_i] <= wr_i.rng_start;
      end
      if (wr_i.we_end) begin
        end_q[wr_idx_i] <= wr_i.rng_end;
      end
    end
  end

  assign rd_start_o = start_q[rd_idx_i];
  assign rd_end_o   = end_q[rd_idx_i];

endmodule

// ===== design/range_read_cache_tracker_unit.sv =====
// range_read_cache_tracker_unit: top level with the sequencer and result register.
// Depends on rrct_pkg, rrct_alu and rrct_slot_file.
`timescale 1ns / 1ps
// A lookup or begin-read beat walks the slots one per cycle through a single
// shared compare/subtract unit, while the same unit folds the slot hint into
// hint mod SLOTS one hex digit per cycle. Lookup and begin-read go from idle
// through the scan state to the finish state; read-completed, disable and any
// no-target error go from idle straight to finish. in_ready_o is low while an
// item is in flight; a finished result sits in the output register, so the next
// beat can be taken while it waits, and the finish step stalls only if the
// previous result has still not been taken. Configuration writes land at once.
module range_read_cache_tracker_unit import rrct_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCAN_STEPS = (SLOTS > MOD_STEPS) ? SLOTS : MOD_STEPS;
  localparam int CNT_W      = $clog2(SCAN_STEPS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [31:0]             bsize_q;
  logic [4:0]              align_q;
  logic [SLOT_FIELD_W-1:0] tgt_q, tgt_d;
  logic                    tgt_vld_q, tgt_vld_d;
  logic                    found_q, found_d;
  logic                    out_vld_q, out_vld_d;
  out_item_t               out_q, out_d;

  in_item_t                req_q;
  logic [63:0]             base_q;
  logic [HINT_W-1:0]       hint_q;
  logic [SLOT_FIELD_W-1:0] rem_q;
  logic [SLOT_FIELD_W-1:0] hit_idx_q;
  logic [31:0]             pos_q, hlen_q, len_q;

  logic                    in_acc, fin_go, slot_step, mod_step;
  logic [IDX_W-1:0]        slot_idx, rd_idx;
  logic [63:0]             rd_start, rd_end, align_mask;
  logic [31:0]             n_bytes;
  logic                    hit_now, gap_ok;
  alu_req_t                alu_req;
  alu_rsp_t                alu_rsp;
  slot_wr_t                wr;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign fin_go      = (state_q == ST_FIN) && (!out_vld_q || out_ready_i);

  assign slot_idx  = cnt_q[IDX_W-1:0];
  assign slot_step = ({1'b0, cnt_q} < (CNT_W + 1)'(SLOTS));
  assign mod_step  = ({1'b0, cnt_q} < (CNT_W + 1)'(MOD_STEPS));
  assign rd_idx    = (state_q == ST_SCAN) ? slot_idx : tgt_q[IDX_W-1:0];
  assign align_mask = ~((64'd1 << align_q) - 64'd1);
  assign n_bytes   = (req_q.byte_cnt < bsize_q) ? req_q.byte_cnt : bsize_q;

  rrct_slot_file #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_slots (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (rd_idx),
    .rd_start_o (rd_start),
    .rd_end_o   (rd_end),
    .wr_idx_i   (tgt_q[IDX_W-1:0]),
    .wr_i       (wr)
  );

  always_comb begin
    alu_req.sub0_a = req_q.offset;
    alu_req.sub0_b = rd_start;
    if (req_q.op == OP_LOOKUP) begin
      alu_req.sub1_a = rd_end;
      alu_req.sub1_b = req_q.offset;
    end else begin
      alu_req.sub1_a = rd_start;
      alu_req.sub1_b = base_q;
    end
    alu_req.add_a = rd_start;
    alu_req.add_b = n_bytes;
    alu_req.rem   = rem_q;
    alu_req.digit = hint_q[HINT_W-1 -: DIGIT_W];
  end

  rrct_alu #(.SLOTS(SLOTS)) u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // lookup: start <= offset < end; begin-read: a non-target slot with start above base and gap shorter
  assign hit_now = !alu_rsp.brw0 && !alu_rsp.brw1 && (alu_rsp.diff1 != 64'd0);
  assign gap_ok  = (slot_idx != tgt_q[IDX_W-1:0]) && !alu_rsp.brw1 &&
                   (alu_rsp.diff1 != 64'd0) && (alu_rsp.diff1[63:32] == 32'd0) &&
                   (alu_rsp.diff1[31:0] < len_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    tgt_d     = tgt_q;
    tgt_vld_d = tgt_vld_q;
    found_d   = found_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    wr        = '0;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d   = '0;
          found_d = 1'b0;
          if (in_data_i.op == OP_LOOKUP || (in_data_i.op == OP_BEGIN && tgt_vld_q)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (slot_step && req_q.op == OP_LOOKUP && hit_now) begin
          found_d = 1'b1;
        end
        if (cnt_q == CNT_W'(SCAN_STEPS - 1)) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d   = ST_IDLE;
          out_vld_d = 1'b1;
          out_d     = '0;
          if (req_q.op == OP_LOOKUP) begin
            if (found_q) begin
              out_d.hit      = 1'b1;
              out_d.slot     = hit_idx_q;
              out_d.position = pos_q;
              out_d.length   = hlen_q;
            end else begin
              tgt_d     = rem_q;
              tgt_vld_d = 1'b1;
            end
          end else if (!tgt_vld_q) begin
            out_d.status = 1'b1;
          end else begin
            unique case (req_q.op)
              OP_BEGIN: begin
                wr.we_start       = 1'b1;
                wr.rng_start      = base_q;
                out_d.slot        = tgt_q;
                out_d.length      = len_q;
                out_d.read_offset = base_q;
              end
              OP_COMPLETE: begin
                wr.we_end  = 1'b1;
                wr.rng_end = alu_rsp.carry ? 64'hFFFF_FFFF_FFFF_FFFF : alu_rsp.sum;
                tgt_vld_d  = 1'b0;
              end
              default: begin
                wr.we_start = 1'b1;
                wr.we_end   = 1'b1;
              end
            endcase
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      bsize_q   <= BUF_SIZE_RST;
      align_q   <= ALIGN_RST;
      tgt_q     <= '0;
      tgt_vld_q <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      tgt_q     <= tgt_d;
      tgt_vld_q <= tgt_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BUFFER_SIZE: bsize_q <= cfg_wdata_i;
          CFG_ALIGN_LOG2:  align_q <= cfg_wdata_i[4:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_acc) begin
      req_q  <= in_data_i;
      base_q <= in_data_i.offset & align_mask;
      hint_q <= in_data_i.slot_hint;
      rem_q  <= '0;
      len_q  <= bsize_q;
    end else if (state_q == ST_SCAN) begin
      if (mod_step) begin
        rem_q  <= alu_rsp.rem;
        hint_q <= hint_q << DIGIT_W;
      end
      if (slot_step && req_q.op == OP_LOOKUP && hit_now && !found_q) begin
        hit_idx_q <= SLOT_FIELD_W'(slot_idx);
        pos_q     <= sat32(alu_rsp.diff0);
        hlen_q    <= sat32(alu_rsp.diff1);
      end
      if (slot_step && req_q.op == OP_BEGIN && gap_ok) begin
        len_q <= alu_rsp.diff1[31:0];
      end
    end
  end

endmodule

// ===== design/rrct_checker.sv =====
// rrct_checker: port-level assertions for range_read_cache_tracker_unit,
// bound to the top level. Depends on rrct_pkg.
`timescale 1ns / 1ps
module rrct_checker import rrct_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // one item in flight: busy right after an input beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // error results carry nothing else
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> !out_data_o.hit && out_data_o.length == 32'd0)
    else $error("error result with payload");

  // a hit always has at least one byte left
  a_hit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.length != 32'd0 && !out_data_o.status)
    else $error("hit with zero length");

endmodule

bind range_read_cache_tracker_unit rrct_checker u_rrct_checker (.*);
